/* sv/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk_s, rst_s, cond, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) else $error(msg);

// Checked during reset as well
`define CHK_ALWAYS(label, clk_s, cond, msg) \
  label: assert property (@(posedge clk_s) (cond)) else $error(msg);

`endif

/* sv/rims_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rims_pkg
// Shared constants and types for the run insertion / merge sorter.
// ----------------------------------------------------------------------------
package rims_pkg;

  localparam int MaxItemsDef  = 64;
  localparam int RunLengthDef = 32;
  localparam int DataW        = 32;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INS_START,
    ST_INS_RD,
    ST_INS_CMP,
    ST_MRG_START,
    ST_MRG_COPY,
    ST_MRG_RD,
    ST_MRG_RDB,
    ST_MRG_CMP,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

  // Signed greater-than on two raw patterns
  function automatic logic sgt(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    sgt = $signed(a) > $signed(b);
  endfunction

endpackage

/* sv/rims_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rims_mem
// Single write, single registered read memory for the element store and the
// merge buffer.
// ----------------------------------------------------------------------------
module rims_mem #(
  parameter int Depth = rims_pkg::MaxItemsDef,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AddrW-1:0]            waddr,
  input  logic [rims_pkg::DataW-1:0]  wdata,
  input  logic [AddrW-1:0]            raddr,
  output logic [rims_pkg::DataW-1:0]  rdata
);

  logic [rims_pkg::DataW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/run_insertion_merge_sorter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_insertion_merge_sorter
// Collects signed items, sorts them with insertion runs and bottom-up merges,
// then emits them as one ascending burst.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (value, last, valid/stall): one item is stored per cycle
//   while loading. Up to MAX_ITEMS are kept; further items are dropped and
//   overflowed is raised on every item of the following burst.
//   An item with last set ends the set; stall is then held high while the
//   block sorts and emits.
//   Sorting runs through one shared signed comparator and single-read-port
//   memories: insertion reads each key, then shifts larger elements up one
//   at a time; each merge pass copies the range into the buffer, fetches
//   both heads and writes the smaller back; the burst reads each item
//   from the store before it is emitted.
//   Output channel (sorted_value, end_of_set, overflowed, out_valid/out_stall):
//   items leave through an output register, each read from the store first;
//   the block holds while out_stall is high. end_of_set marks the final item.
//   Reset (rst, synchronous) returns to loading with an empty set; the
//   memories need no clearing.
// ----------------------------------------------------------------------------
module run_insertion_merge_sorter #(
  parameter int MAX_ITEMS  = rims_pkg::MaxItemsDef,
  parameter int RUN_LENGTH = rims_pkg::RunLengthDef
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [rims_pkg::DataW-1:0] value,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [rims_pkg::DataW-1:0] sorted_value,
  output logic                              end_of_set,
  output logic                              overflowed
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int IW = $clog2(MAX_ITEMS + RUN_LENGTH) + 2;  // index with headroom for bounds
  localparam logic [IW-1:0] RunL = IW'(RUN_LENGTH);

  rims_pkg::state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic          drop, drop_next;
  logic [IW-1:0] i, i_next, j, j_next, lo, lo_next, hi, hi_next;
  logic [IW-1:0] width, width_next, a, a_next, b, b_next, k, k_next;
  logic [IW-1:0] mid, mid_next;
  logic [rims_pkg::DataW-1:0] key, key_next, va, va_next;

  // store
  logic                       s_we, b_we;
  logic [AW-1:0]              s_wa, s_ra, b_wa, b_ra;
  logic [rims_pkg::DataW-1:0] s_wd, s_rd, b_rd;

  rims_mem #(.Depth(MAX_ITEMS)) u_store (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  rims_mem #(.Depth(MAX_ITEMS)) u_buf (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(s_rd), .raddr(b_ra), .rdata(b_rd));

  logic [IW-1:0] n_ext;
  logic          o_load;
  logic          o_valid;
  logic [rims_pkg::DataW-1:0] o_val;
  logic          o_end, o_ovf;
  logic          cmp_gt;
  logic [rims_pkg::DataW-1:0] cmp_a, cmp_b;
  logic          a_ok, b_ok;

  assign n_ext  = IW'(count);
  assign cmp_gt = rims_pkg::sgt(cmp_a, cmp_b);
  assign a_ok   = (a <= mid);
  assign b_ok   = (b <= hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rims_pkg::ST_LOAD;
      count   <= '0;
      drop    <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      drop  <= drop_next;
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (!out_stall) begin
        o_valid <= 1'b0;
      end
    end
    i <= i_next; j <= j_next; lo <= lo_next; hi <= hi_next;
    width <= width_next; a <= a_next; b <= b_next; k <= k_next; mid <= mid_next;
    key <= key_next; va <= va_next;
    if (o_load) begin
      o_val <= s_rd;
      o_end <= (k + 1'b1 == n_ext);
      o_ovf <= drop;
    end
  end

  assign out_valid    = o_valid;
  assign sorted_value = o_val;
  assign end_of_set   = o_end;
  assign overflowed   = o_ovf;
  assign in_stall     = (state != rims_pkg::ST_LOAD);

  always_comb begin
    state_next = state;
    count_next = count; drop_next = drop;
    i_next = i; j_next = j; lo_next = lo; hi_next = hi;
    width_next = width; a_next = a; b_next = b; k_next = k; mid_next = mid;
    key_next = key; va_next = va;
    s_we = 1'b0; s_wa = '0; s_wd = value; s_ra = '0;
    b_we = 1'b0; b_wa = '0; b_ra = '0;
    cmp_a = s_rd; cmp_b = key;
    o_load = 1'b0;
    unique case (state)
      rims_pkg::ST_LOAD: begin
        if (in_valid) begin
          if (count < CW'(MAX_ITEMS)) begin
            s_we = 1'b1; s_wa = AW'(count); s_wd = value;
            count_next = count + 1'b1;
          end else begin
            drop_next = 1'b1;
          end
          if (last) begin
            lo_next = '0;
            state_next = rims_pkg::ST_INS_START;
          end
        end
      end
      // lo: run start; i walks the run, j the insertion point
      rims_pkg::ST_INS_START: begin
        if (lo >= n_ext) begin
          width_next = RunL;
          state_next = rims_pkg::ST_MRG_START;
          lo_next = '0;
        end else begin
          hi_next = (lo + RunL > n_ext) ? n_ext - 1'b1 : lo + RunL - 1'b1;
          i_next = lo + 1'b1;
          s_ra = AW'(lo + 1'b1);
          state_next = rims_pkg::ST_INS_RD;
        end
      end
      rims_pkg::ST_INS_RD: begin
        // key arrives; fetch element j-1
        if (i > hi) begin
          lo_next = lo + RunL;
          state_next = rims_pkg::ST_INS_START;
        end else begin
          key_next = s_rd;
          j_next = i;
          s_ra = AW'(i - 1'b1);
          state_next = rims_pkg::ST_INS_CMP;
        end
      end
      rims_pkg::ST_INS_CMP: begin
        cmp_a = s_rd; cmp_b = key;
        if (j > lo && cmp_gt) begin
          s_we = 1'b1; s_wa = AW'(j); s_wd = s_rd;
          j_next = j - 1'b1;
          s_ra = AW'(j - 2'd2);
        end else begin
          s_we = 1'b1; s_wa = AW'(j); s_wd = key;
          i_next = i + 1'b1;
          s_ra = AW'(i + 1'b1);
          state_next = rims_pkg::ST_INS_RD;
        end
      end
      // lo: merge start; copy lo..hi into buffer then merge back
      rims_pkg::ST_MRG_START: begin
        if (width >= n_ext) begin
          k_next = '0;
          s_ra = '0;
          state_next = rims_pkg::ST_EMIT_RD;
        end else if (lo >= n_ext) begin
          width_next = width << 1;
          lo_next = '0;
        end else begin
          mid_next = lo + width - 1'b1;
          hi_next = (lo + (width << 1) > n_ext) ? n_ext - 1'b1 : lo + (width << 1) - 1'b1;
          if (lo + width - 1'b1 >= ((lo + (width << 1) > n_ext) ? n_ext - 1'b1
                                    : lo + (width << 1) - 1'b1)) begin
            lo_next = lo + (width << 1);
          end else begin
            k_next = lo;
            s_ra = AW'(lo);
            state_next = rims_pkg::ST_MRG_COPY;
          end
        end
      end
      rims_pkg::ST_MRG_COPY: begin
        // s_rd holds element k (read last cycle)
        b_we = 1'b1; b_wa = AW'(k);
        k_next = k + 1'b1;
        s_ra = AW'(k + 1'b1);
        if (k == hi) begin
          a_next = lo; b_next = mid + 1'b1; k_next = lo;
          state_next = rims_pkg::ST_MRG_RD;
        end
      end
      rims_pkg::ST_MRG_RD: begin
        if (k > hi) begin
          lo_next = lo + (width << 1);
          state_next = rims_pkg::ST_MRG_START;
        end else begin
          b_ra = AW'(a);
          state_next = rims_pkg::ST_MRG_RDB;
        end
      end
      rims_pkg::ST_MRG_RDB: begin
        // left head arrives; fetch the right head
        va_next = b_rd;
        b_ra = AW'(b);
        state_next = rims_pkg::ST_MRG_CMP;
      end
      rims_pkg::ST_MRG_CMP: begin
        // take the left head on equal keys to keep the order stable
        cmp_a = va; cmp_b = b_rd;
        s_we = 1'b1; s_wa = AW'(k);
        if (a_ok && (!b_ok || !cmp_gt)) begin
          s_wd = va;
          a_next = a + 1'b1;
        end else begin
          s_wd = b_rd;
          b_next = b + 1'b1;
        end
        k_next = k + 1'b1;
        state_next = rims_pkg::ST_MRG_RD;
      end
      rims_pkg::ST_EMIT_RD: begin
        s_ra = AW'(k);
        state_next = rims_pkg::ST_EMIT;
      end
      rims_pkg::ST_EMIT: begin
        s_ra = AW'(k);
        if (!o_valid || !out_stall) begin
          o_load = 1'b1;
          k_next = k + 1'b1;
          if (k + 1'b1 == n_ext) begin
            count_next = '0; drop_next = 1'b0;
            state_next = rims_pkg::ST_LOAD;
          end else begin
            state_next = rims_pkg::ST_EMIT_RD;
          end
        end
      end
      default: state_next = rims_pkg::ST_LOAD;
    endcase
  end

endmodule

/* sv/rims_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rims_checker
// Port-level checks for the sorter, bound to the top level.
// ----------------------------------------------------------------------------
module rims_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       last,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [rims_pkg::DataW-1:0] sorted_value,
  input logic                       end_of_set,
  input logic                       overflowed
);

  `CHK_IMPLY(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "output dropped")
  `CHK_IMPLY(a_out_stable, clk, rst, out_valid && out_stall |=> $stable(sorted_value) && $stable(end_of_set) && $stable(overflowed), "stalled output changed")
  `CHK_IMPLY(a_last_stalls, clk, rst, in_valid && !in_stall && last |=> in_stall, "input open after last item")
  `CHK_ALWAYS(a_reset_idle, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind run_insertion_merge_sorter rims_checker u_rims_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .last(last),
  .out_valid(out_valid), .out_stall(out_stall), .sorted_value(sorted_value),
  .end_of_set(end_of_set), .overflowed(overflowed));

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sets of signed items into the run insertion / merge sorter and checks
// every emitted item against a predicted stable ascending sort of the set.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MaxSet   = rims_pkg::MaxItemsDef;
  localparam int RunLen   = rims_pkg::RunLengthDef;
  localparam int CycLimit = 2000000;

  typedef struct packed {
    logic signed [rims_pkg::DataW-1:0] value;
    logic                              last;
  } load_item_t;

  typedef struct packed {
    logic signed [rims_pkg::DataW-1:0] value;
    logic                              eos;
    logic                              ovf;
  } sorted_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [rims_pkg::DataW-1:0] value = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [rims_pkg::DataW-1:0] sorted_value;
  logic end_of_set;
  logic overflowed;

  run_insertion_merge_sorter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .value(value), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .sorted_value(sorted_value), .end_of_set(end_of_set), .overflowed(overflowed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  load_item_t   pending_q[$];
  sorted_item_t sorted_q[$];

  // predictor state
  logic signed [rims_pkg::DataW-1:0] set_store[MaxSet];
  logic signed [rims_pkg::DataW-1:0] set_scratch[MaxSet];
  int  set_count = 0;
  bit  set_dropped = 0;

  int  errors = 0;
  int  sets_done = 0;
  int  items_in = 0;
  int  items_out = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_off = 0;
  bit  sender_paused = 0;
  bit  took_item = 0;
  longint cycles = 0;

  task automatic report(input string what);
    errors++;
    $display("MISMATCH %0s at cycle %0d", what, cycles);
  endtask

  function automatic void merge_runs(input int lo, input int mid, input int hi);
    int a, b, k;
    a = lo; b = mid + 1; k = lo;
    for (int i = lo; i <= hi; i++) set_scratch[i] = set_store[i];
    while (a <= mid && b <= hi) begin
      if (set_scratch[a] <= set_scratch[b]) set_store[k++] = set_scratch[a++];
      else set_store[k++] = set_scratch[b++];
    end
    while (a <= mid) set_store[k++] = set_scratch[a++];
    while (b <= hi) set_store[k++] = set_scratch[b++];
  endfunction

  // Stored-and-sorted prediction for one accepted item
  function automatic void predict_sorted(input load_item_t it);
    int n, hi, j;
    logic signed [rims_pkg::DataW-1:0] key;
    sorted_item_t r;
    if (set_count < MaxSet) set_store[set_count++] = it.value;
    else set_dropped = 1;
    if (!it.last) return;
    n = set_count;
    for (int s = 0; s < n; s += RunLen) begin
      hi = (s + RunLen - 1 > n - 1) ? n - 1 : s + RunLen - 1;
      for (int i = s + 1; i <= hi; i++) begin
        key = set_store[i];
        j = i;
        while (j > s && set_store[j-1] > key) begin
          set_store[j] = set_store[j-1];
          j--;
        end
        set_store[j] = key;
      end
    end
    for (int w = RunLen; w < n; w *= 2)
      for (int s = 0; s < n; s += 2 * w) begin
        hi = (s + 2 * w - 1 > n - 1) ? n - 1 : s + 2 * w - 1;
        if (s + w - 1 < hi) merge_runs(s, s + w - 1, hi);
      end
    for (int k = 0; k < n; k++) begin
      r.value = set_store[k];
      r.eos = (k == n - 1);
      r.ovf = set_dropped;
      sorted_q.push_back(r);
    end
    set_count = 0;
    set_dropped = 0;
  endfunction

  function automatic logic signed [rims_pkg::DataW-1:0] pick_value(input int mode);
    case (mode)
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom_range(7) - 3;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_set(input int n, input int mode);
    load_item_t it;
    for (int i = 0; i < n; i++) begin
      it.value = pick_value(mode == 4 ? $urandom_range(3) : mode);
      it.last = (i == n - 1);
      pending_q.push_back(it);
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || took_item) begin
        if (pending_q.size() > 0 && !sender_paused &&
            $urandom_range(99) >= send_idle_pct) begin
          {value, last} <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (hold_off > 0) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // receiver hold-off countdown
  always @(posedge clk) begin
    if (hold_off > 0) hold_off--;
  end

  // monitor
  always @(posedge clk) begin
    load_item_t seen;
    cycles++;
    took_item = 0;
    if (!rst && in_valid && !in_stall) begin
      took_item = 1;
      items_in++;
      seen.value = value;
      seen.last = last;
      predict_sorted(seen);
      if (last) sets_done++;
    end
    if (!rst && out_valid && !out_stall) begin
      items_out++;
      if (sorted_q.size() == 0) report("unexpected sorted item");
      else begin
        sorted_item_t exp_r;
        exp_r = sorted_q.pop_front();
        if (sorted_value !== exp_r.value)
          report($sformatf("sorted_value got %0d want %0d", sorted_value, exp_r.value));
        if (end_of_set !== exp_r.eos)
          report($sformatf("end_of_set got %b want %b", end_of_set, exp_r.eos));
        if (overflowed !== exp_r.ovf)
          report($sformatf("overflowed got %b want %b", overflowed, exp_r.ovf));
      end
    end
    if (cycles > CycLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid || sorted_q.size() > 0 || set_count > 0)
      @(posedge clk);
  endtask

  task automatic queue_random(input int items);
    int sent, n, m;
    sent = 0;
    while (sent < items) begin
      m = $urandom_range(9);
      if (m == 0) n = MaxSet + $urandom_range(1, 10);
      else if (m == 1) n = $urandom_range(33, 64);
      else n = $urandom_range(1, 12);
      queue_set(n, m == 2 ? 2 : 4);
      sent += n;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: single item, extremes, duplicates, exact run, overflow
    queue_set(1, 0);
    queue_set(2, 1);
    for (int i = 0; i < 4; i++) begin
      load_item_t it;
      it.value = (i % 2) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      it.last = (i == 3);
      pending_q.push_back(it);
    end
    queue_set(6, 2);
    wait_drained();
    queue_set(RunLen, 4);
    queue_set(RunLen + 1, 4);
    queue_set(MaxSet + 3, 4);
    wait_drained();

    // long receiver hold-off so the block fills and stalls its input
    hold_off = 3000;
    queue_set(MaxSet, 4);
    queue_set(5, 4);
    wait_drained();

    send_idle_pct = 15; recv_idle_pct = 52;
    queue_random(40);
    // pause the sender once a burst is due, until every result is in
    while (sorted_q.size() == 0) @(posedge clk);
    sender_paused = 1;
    while (sorted_q.size() > 0) @(posedge clk);
    sender_paused = 0;
    wait_drained();
    send_idle_pct = 52; recv_idle_pct = 15;
    queue_random(40);
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;
    queue_random(40);
    wait_drained();
    repeat (200) @(posedge clk);

    $display("covered %0d sets, %0d items loaded, %0d sorted items checked",
             sets_done, items_in, items_out);
    if (errors == 0 && sorted_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
